/* sv/owt_pkg.sv */
// owt_pkg: shared types, codes and the command program of the one-wire
// temperature master. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package owt_pkg;

    // Widths of the stream payloads and the configuration port
    localparam int InDataW  = 8;
    localparam int OutDataW = 24;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 12;
    localparam int PhaseW   = 5;
    localparam int TickW    = 12;

    // Program layout
    localparam logic [PhaseW-1:0] ProgLen      = 5'd17;
    localparam logic [PhaseW-1:0] ConfigFirst  = 5'd1;
    localparam logic [PhaseW-1:0] MeasureFirst = 5'd8;

    // Request codes carried in the action field
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_CONFIG  = 2'd1;
    localparam logic [1:0] ACT_MEASURE = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SLOT_START    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SAMPLE_DELAY  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SLOT_HOLD     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_POLL_LIMIT    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_COMMAND_GAP   = 3'd6;

    // Bus command bytes
    localparam logic [7:0] CMD_SKIP_ROM    = 8'hCC;
    localparam logic [7:0] CMD_WRITE_PAD   = 8'h4E;
    localparam logic [7:0] CMD_CONVERT     = 8'h44;
    localparam logic [7:0] CMD_READ_PAD    = 8'hBE;
    localparam logic [7:0] PAD_HIGH_ALARM  = 8'h20;
    localparam logic [7:0] PAD_LOW_ALARM   = 8'h00;
    localparam logic [7:0] PAD_RESOLUTION  = 8'h7F;

    typedef enum logic [2:0] {
        K_NONE,
        K_RST,
        K_WR,
        K_RD,
        K_GAP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] cmd;
        logic       last;
    } t_op;

    // Effective timing settings, zero timing values already raised to one, except the command gap
    typedef struct packed {
        logic [TickW-1:0] reset_low;
        logic [TickW-1:0] slot_start;
        logic [TickW-1:0] sample_delay;
        logic [TickW-1:0] slot_hold;
        logic [TickW-1:0] poll_interval;
        logic [3:0]       poll_limit;
        logic [TickW-1:0] command_gap;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence_ok;
        logic [11:0] temperature;
        logic        sign_error;
    } t_result;

    // Command program: configure sequence, then measure sequence
    function automatic t_op prog_op(input logic [PhaseW-1:0] p);
        t_op op;
        op = '{kind: K_NONE, cmd: 8'h00, last: 1'b0};
        case (p)
            5'd1:  op = '{kind: K_RST, cmd: 8'h00,           last: 1'b0};
            5'd2:  op = '{kind: K_WR,  cmd: CMD_SKIP_ROM,    last: 1'b0};
            5'd3:  op = '{kind: K_WR,  cmd: CMD_WRITE_PAD,   last: 1'b0};
            5'd4:  op = '{kind: K_WR,  cmd: PAD_HIGH_ALARM,  last: 1'b0};
            5'd5:  op = '{kind: K_WR,  cmd: PAD_LOW_ALARM,   last: 1'b0};
            5'd6:  op = '{kind: K_WR,  cmd: PAD_RESOLUTION,  last: 1'b0};
            5'd7:  op = '{kind: K_RST, cmd: 8'h00,           last: 1'b1};
            5'd8:  op = '{kind: K_RST, cmd: 8'h00,           last: 1'b0};
            5'd9:  op = '{kind: K_GAP, cmd: 8'h00,           last: 1'b0};
            5'd10: op = '{kind: K_WR,  cmd: CMD_SKIP_ROM,    last: 1'b0};
            5'd11: op = '{kind: K_WR,  cmd: CMD_CONVERT,     last: 1'b0};
            5'd12: op = '{kind: K_RST, cmd: 8'h00,           last: 1'b0};
            5'd13: op = '{kind: K_GAP, cmd: 8'h00,           last: 1'b0};
            5'd14: op = '{kind: K_WR,  cmd: CMD_SKIP_ROM,    last: 1'b0};
            5'd15: op = '{kind: K_WR,  cmd: CMD_READ_PAD,    last: 1'b0};
            5'd16: op = '{kind: K_RD,  cmd: 8'h00,           last: 1'b1};
            default: op = '{kind: K_NONE, cmd: 8'h00, last: 1'b0};
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* sv/one_wire_temperature_master.sv */
// one_wire_temperature_master: top level with input and result registers.
// Depends on owt_pkg, owt_cfg and owt_seq.
`timescale 1ns / 1ps
`default_nettype none

// Each input request is one bus tick carrying a start action and the sampled bus
// level; each tick produces exactly one result (drive level, busy, done, presence,
// temperature, sign error). A tick is accepted every clock cycle while the result
// side keeps up; a result is registered: the tick sits in the input register, and
// the sequencer step loads the result register once that register is empty or
// being drained.
// A configure action runs a reset with presence check, writes skip ROM, write
// scratchpad, 0x20, 0x00, 0x7F and ends with a second reset. A measure action runs
// reset, gap, skip ROM, convert, reset, gap, skip ROM, read scratchpad and reads two
// bytes; the result is the 12-bit magnitude, or zero with sign_error when the high
// nibble of the upper byte is set. Starts are ignored while busy. Write the timing
// registers only while no sequence is running.
module one_wire_temperature_master
    import owt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // tdata: [1:0] action, [2] line_sample
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [InDataW-1:0]  i_s_axis_tdata,
    // tdata: [0] drive_low, [1] busy_res, [2] done_res, [3] presence_ok,
    //        [15:4] temperature, [16] sign_error
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [OutDataW-1:0]      o_m_axis_tdata,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    logic       r_in_valid;
    logic [1:0] r_action;
    logic       r_line;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_res;
    t_cfg       cfg;
    logic       step;

    assign o_cfg_ready = 1'b1;

    owt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Run a tick when it is held and the result register can take its result
    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    owt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_action (r_action),
        .i_line   (r_line),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // Hold the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_action <= i_s_axis_tdata[1:0];
            r_line   <= i_s_axis_tdata[2];
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.sign_error, r_out.temperature, r_out.presence_ok,
                              r_out.done_res, r_out.busy_res, r_out.drive_low};

    // A finishing tick is always part of a running sequence
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.busy_res)
        else $error("done without busy");

    // The bus is only pulled low while a sequence runs
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.drive_low |-> r_out.busy_res)
        else $error("drive outside a sequence");

    // A held request that cannot step stays held
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid)
        else $error("held request lost");

    // A result is only loaded into an empty or draining result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !step)
        else $error("result overwritten");

endmodule

`default_nettype wire

/* sv/owt_cfg.sv */
// owt_cfg: configuration register file of the one-wire temperature master.
// Depends on owt_pkg; presents effective timing settings as a t_cfg struct.
`timescale 1ns / 1ps
`default_nettype none

module owt_cfg
    import owt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [CfgIdxW-1:0]  i_wr_index,
    input  wire logic [CfgDataW-1:0] i_wr_data,
    output t_cfg                     o_cfg
);

    logic [9:0]  r_reset_low;
    logic [3:0]  r_slot_start;
    logic [5:0]  r_sample_delay;
    logic [7:0]  r_slot_hold;
    logic [11:0] r_poll_interval;
    logic [3:0]  r_poll_limit;
    logic [11:0] r_command_gap;

    // Load one register per request; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low     <= 10'd500;
            r_slot_start    <= 4'd1;
            r_sample_delay  <= 6'd10;
            r_slot_hold     <= 8'd60;
            r_poll_interval <= 12'd1000;
            r_poll_limit    <= 4'd5;
            r_command_gap   <= 12'd1000;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_RESET_LOW:     r_reset_low     <= i_wr_data[9:0];
                REG_SLOT_START:    r_slot_start    <= i_wr_data[3:0];
                REG_SAMPLE_DELAY:  r_sample_delay  <= i_wr_data[5:0];
                REG_SLOT_HOLD:     r_slot_hold     <= i_wr_data[7:0];
                REG_POLL_INTERVAL: r_poll_interval <= i_wr_data[11:0];
                REG_POLL_LIMIT:    r_poll_limit    <= i_wr_data[3:0];
                REG_COMMAND_GAP:   r_command_gap   <= i_wr_data[11:0];
                default: ;
            endcase
        end
    end

    // Raise zero timing values to one; the gap keeps zero as "skip"
    always_comb begin
        o_cfg.reset_low     = (r_reset_low == '0) ? 12'd1 : 12'(r_reset_low);
        o_cfg.slot_start    = (r_slot_start == '0) ? 12'd1 : 12'(r_slot_start);
        o_cfg.sample_delay  = (r_sample_delay == '0) ? 12'd1 : 12'(r_sample_delay);
        o_cfg.slot_hold     = (r_slot_hold == '0) ? 12'd1 : 12'(r_slot_hold);
        o_cfg.poll_interval = (r_poll_interval == '0) ? 12'd1 : r_poll_interval;
        o_cfg.poll_limit    = r_poll_limit;
        o_cfg.command_gap   = r_command_gap;
    end

endmodule

`default_nettype wire

/* sv/owt_seq.sv */
// owt_seq: bus sequencer of the one-wire temperature master; one tick per step.
// Depends on owt_pkg; holds all sequence state and computes the tick's result.
`timescale 1ns / 1ps
`default_nettype none

module owt_seq
    import owt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_action,
    input  wire logic       i_line,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RLOW,
        ST_RPOLL,
        ST_RWAIT,
        ST_WLOW,
        ST_WBIT,
        ST_WREC,
        ST_DLOW,
        ST_DWAIT,
        ST_DHOLD,
        ST_GAP
    } t_stage;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        t_stage            stage;
        logic [TickW-1:0]  tick;
        logic [2:0]        bit_idx;
        logic              byte_idx;
        logic [7:0]        shift;
        logic [3:0]        poll;
        logic [7:0]        low_byte;
        logic [11:0]       temp;
        logic              presence;
        logic              sign;
    } t_seq_st;

    t_seq_st r_st, n_st;

    // Start program step p, skipping a gap step when the gap is zero
    function automatic t_seq_st enter_op(input t_seq_st s_in, input logic [PhaseW-1:0] p,
                                         input logic gap_zero);
        t_seq_st           s;
        t_op               op;
        logic [PhaseW-1:0] pe;
        s  = s_in;
        pe = p;
        op = prog_op(p);
        if (op.kind == K_GAP && gap_zero) begin
            pe = p + 5'd1;
            op = prog_op(pe);
        end
        s.phase    = pe;
        s.tick     = '0;
        s.bit_idx  = '0;
        s.byte_idx = 1'b0;
        s.poll     = '0;
        case (op.kind)
            K_RST: s.stage = ST_RLOW;
            K_WR: begin
                s.stage = ST_WLOW;
                s.shift = op.cmd;
            end
            K_RD: begin
                s.stage = ST_DLOW;
                s.shift = '0;
            end
            K_GAP: s.stage = ST_GAP;
            default: begin
                s.phase = '0;
                s.stage = ST_IDLE;
            end
        endcase
        return s;
    endfunction

    t_seq_st          s;
    logic             drive, busy, done, fin, gap_zero;
    logic [TickW-1:0] tick_inc;

    // Advance the sequence by one tick
    always_comb begin
        s        = r_st;
        drive    = 1'b0;
        busy     = 1'b0;
        done     = 1'b0;
        fin      = 1'b0;
        gap_zero = (i_cfg.command_gap == '0);

        // Take a start request only while idle
        if (s.phase == '0 || s.phase >= ProgLen) begin
            s.phase = '0;
            s.stage = ST_IDLE;
            if (i_action == ACT_CONFIG) begin
                s = enter_op(s, ConfigFirst, gap_zero);
            end else if (i_action == ACT_MEASURE) begin
                s = enter_op(s, MeasureFirst, gap_zero);
            end
        end

        tick_inc = s.tick + 12'd1;

        if (s.phase != '0) begin
            busy = 1'b1;
            case (s.stage)
                ST_RLOW: begin
                    drive  = 1'b1;
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.reset_low) begin
                        s.stage = ST_RPOLL;
                        s.tick  = '0;
                    end
                end
                ST_RPOLL: begin
                    if (!i_line) begin
                        s.presence = 1'b1;
                        fin        = 1'b1;
                    end else if (s.poll >= i_cfg.poll_limit) begin
                        s.presence = 1'b0;
                        fin        = 1'b1;
                    end else begin
                        s.poll  = s.poll + 4'd1;
                        s.tick  = '0;
                        s.stage = (i_cfg.poll_interval <= 12'd1) ? ST_RPOLL : ST_RWAIT;
                    end
                end
                ST_RWAIT: begin
                    s.tick = tick_inc;
                    if ({1'b0, tick_inc} + 13'd1 >= {1'b0, i_cfg.poll_interval}) begin
                        s.stage = ST_RPOLL;
                        s.tick  = '0;
                    end
                end
                ST_GAP: begin
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.command_gap) begin
                        fin = 1'b1;
                    end
                end
                ST_WLOW: begin
                    drive  = 1'b1;
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.slot_start) begin
                        s.stage = ST_WBIT;
                        s.tick  = '0;
                    end
                end
                ST_WBIT: begin
                    drive  = ~s.shift[0];
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.slot_hold) begin
                        s.stage = ST_WREC;
                        s.tick  = '0;
                    end
                end
                ST_WREC: begin
                    s.shift = {1'b0, s.shift[7:1]};
                    if (s.bit_idx == 3'd7) begin
                        fin = 1'b1;
                    end else begin
                        s.bit_idx = s.bit_idx + 3'd1;
                        s.stage   = ST_WLOW;
                        s.tick    = '0;
                    end
                end
                ST_DLOW: begin
                    drive  = 1'b1;
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.slot_start) begin
                        s.stage = ST_DWAIT;
                        s.tick  = '0;
                    end
                end
                ST_DWAIT: begin
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.sample_delay) begin
                        s.shift = {i_line, s.shift[7:1]};
                        s.stage = ST_DHOLD;
                        s.tick  = '0;
                    end
                end
                ST_DHOLD: begin
                    s.tick = tick_inc;
                    if (tick_inc >= i_cfg.slot_hold) begin
                        s.tick  = '0;
                        s.stage = ST_DLOW;
                        if (s.bit_idx != 3'd7) begin
                            s.bit_idx = s.bit_idx + 3'd1;
                        end else if (!s.byte_idx) begin
                            s.low_byte = s.shift;
                            s.byte_idx = 1'b1;
                            s.bit_idx  = '0;
                            s.shift    = '0;
                        end else begin
                            // Upper nibble of the high byte set: flag and clear
                            if (s.shift[7:4] != 4'h0) begin
                                s.temp = '0;
                                s.sign = 1'b1;
                            end else begin
                                s.temp = {s.shift[3:0], s.low_byte};
                                s.sign = 1'b0;
                            end
                            fin = 1'b1;
                        end
                    end
                end
                default: begin
                    s.phase = '0;
                    s.stage = ST_IDLE;
                end
            endcase

            // Close the step: finish the sequence or move to the next step
            if (fin) begin
                if (prog_op(s.phase).last) begin
                    done    = 1'b1;
                    s.phase = '0;
                    s.stage = ST_IDLE;
                end else begin
                    s = enter_op(s, s.phase + 5'd1, gap_zero);
                end
            end
        end

        n_st = i_step ? s : r_st;

        o_result.drive_low   = drive;
        o_result.busy_res    = busy;
        o_result.done_res    = done;
        o_result.presence_ok = s.presence;
        o_result.temperature = s.temp;
        o_result.sign_error  = s.sign;
    end

    // Hold sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{phase: '0, stage: ST_IDLE, tick: '0, bit_idx: '0, byte_idx: 1'b0,
                      shift: '0, poll: '0, low_byte: '0, temp: '0, presence: 1'b0,
                      sign: 1'b0};
        end else begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire
